### rtl/trls_pkg.sv
package trls_pkg;

    localparam int STAMP_W         = 33;
    localparam int PORT_ID_W       = 16;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF    = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [1:0] STS_MATCH  = 2'd0;
    localparam logic [1:0] STS_NONE   = 2'd1;
    localparam logic [1:0] STS_STORED = 2'd2;
    localparam logic [1:0] STS_FULL   = 2'd3;

    localparam logic [2:0] GR_YEAR   = 3'd0;
    localparam logic [2:0] GR_MONTH  = 3'd1;
    localparam logic [2:0] GR_DAY    = 3'd2;
    localparam logic [2:0] GR_HOUR   = 3'd3;
    localparam logic [2:0] GR_MINUTE = 3'd4;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] DAY_LAST    = 5'd31;
    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;
    localparam logic [5:0] SECOND_LAST = 6'd59;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_stamp;

    // One queued command: put uses lo as its key, retrieve uses lo..hi.
    typedef struct packed {
        logic                 cmd;
        logic [PORT_ID_W-1:0] id;
        logic [STAMP_W-1:0]   lo;
        logic [STAMP_W-1:0]   hi;
    } t_cmd_entry;

    typedef struct packed {
        logic                 vld;
        logic [PORT_ID_W-1:0] id;
        logic [1:0]           status;
        logic                 last;
    } t_result;

    // Force the fields below the granularity to their first or last value.
    function automatic logic [STAMP_W-1:0] widen_stamp(input logic [STAMP_W-1:0] s,
                                                        input logic [2:0] g,
                                                        input logic is_end);
        t_stamp r;
        r = t_stamp'(s);
        if (g == GR_YEAR) begin
            r.month = is_end ? MONTH_LAST : MONTH_FIRST;
        end
        if (g <= GR_MONTH) begin
            r.day = is_end ? DAY_LAST : DAY_FIRST;
        end
        if (g <= GR_DAY) begin
            r.hour = is_end ? HOUR_LAST : 5'd0;
        end
        if (g <= GR_HOUR) begin
            r.minute = is_end ? MINUTE_LAST : 6'd0;
        end
        if (g <= GR_MINUTE) begin
            r.second = is_end ? SECOND_LAST : 6'd0;
        end
        return STAMP_W'(r);
    endfunction

endpackage

### rtl/trls_front.sv
module trls_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_command,
    input  logic [trls_pkg::PORT_ID_W-1:0] i_log_id,
    input  logic [trls_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [trls_pkg::STAMP_W-1:0]  i_stamp_end,
    input  logic [2:0]                    i_granularity,
    input  logic                          i_q_full,
    output logic                          o_push,
    output trls_pkg::t_cmd_entry          o_entry
);
    import trls_pkg::*;

    logic       r_vld, n_vld;
    t_cmd_entry r_entry, n_entry;
    logic       w_accept;

    assign o_busy   = r_vld && i_q_full;
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_vld && !i_q_full;
    assign o_entry  = r_entry;

    always_comb begin
        n_vld   = r_vld;
        n_entry = r_entry;
        if (o_push) begin
            n_vld = 1'b0;
        end
        if (w_accept) begin
            n_vld       = 1'b1;
            n_entry.cmd = i_command;
            n_entry.id  = i_log_id;
            // a put keeps its stamp as the key
            n_entry.lo  = (i_command == CMD_PUT) ? i_stamp
                                                 : widen_stamp(i_stamp, i_granularity, 1'b0);
            n_entry.hi  = widen_stamp(i_stamp_end, i_granularity, 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### rtl/trls_fifo.sv
module trls_fifo #(
    parameter int DEPTH = trls_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  trls_pkg::t_cmd_entry i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output trls_pkg::t_cmd_entry o_head
);
    import trls_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd_entry      r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### rtl/trls_back.sv
module trls_back #(
    parameter int TABLE_DEPTH = trls_pkg::TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = trls_pkg::ID_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  trls_pkg::t_cmd_entry i_entry,
    output logic                 o_pop,
    output trls_pkg::t_result    o_result
);
    import trls_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    typedef struct packed {
        logic [STAMP_W-1:0]  key;
        logic [ID_WIDTH-1:0] id;
    } t_entry;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;

    logic [1:0]          r_state, n_state;
    logic                r_cmd, n_cmd;
    logic [ID_WIDTH-1:0] r_id, n_id;
    logic [STAMP_W-1:0]  r_lo, n_lo;
    logic [STAMP_W-1:0]  r_hi, n_hi;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_pv, n_pv;
    logic [AW-1:0]       r_didx, n_didx;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_sh, n_sh;
    logic                r_hold_vld, n_hold_vld;
    logic [ID_WIDTH-1:0] r_hold_id, n_hold_id;
    logic                r_out_vld, n_out_vld;
    logic [ID_WIDTH-1:0] r_out_id, n_out_id;
    logic [1:0]          r_out_st, n_out_st;
    logic                r_out_last, n_out_last;

    logic                w_we, w_re;
    logic [AW-1:0]       w_waddr, w_raddr;
    t_entry              w_wdata;
    logic                w_more;
    logic                w_done;
    logic [CW-1:0]       w_sh_m1;
    logic [ID_WIDTH+PORT_ID_W-1:0] w_id_ext;
    logic [ID_WIDTH+PORT_ID_W-1:0] w_oid_ext;

    assign w_more    = (r_addr < r_count);
    assign w_done    = !r_pv && !w_more;
    assign w_sh_m1   = r_sh - CW'(1);
    assign w_id_ext  = {{ID_WIDTH{1'b0}}, i_entry.id};
    assign w_oid_ext = {{PORT_ID_W{1'b0}}, r_out_id};

    assign o_result.vld    = r_out_vld;
    assign o_result.id     = w_oid_ext[PORT_ID_W-1:0];
    assign o_result.status = r_out_st;
    assign o_result.last   = r_out_last;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_id       = r_id;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pv       = 1'b0;
        n_didx     = r_didx;
        n_pos      = r_pos;
        n_sh       = r_sh;
        n_hold_vld = r_hold_vld;
        n_hold_id  = r_hold_id;
        n_out_vld  = 1'b0;
        n_out_id   = '0;
        n_out_st   = STS_MATCH;
        n_out_last = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_didx;
        w_wdata    = r_rd;
        w_re       = 1'b0;
        w_raddr    = r_addr[AW-1:0];
        o_pop      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_entry.cmd;
                    n_id       = w_id_ext[ID_WIDTH-1:0];
                    n_lo       = i_entry.lo;
                    n_hi       = i_entry.hi;
                    n_addr     = '0;
                    n_hold_vld = 1'b0;
                    n_state    = S_SCAN;
                end
            end

            S_SCAN: begin
                // stream reads through the sorted table, one entry a cycle
                if (w_more) begin
                    w_re    = 1'b1;
                    w_raddr = r_addr[AW-1:0];
                    n_addr  = r_addr + CW'(1);
                    n_pv    = 1'b1;
                    n_didx  = r_addr[AW-1:0];
                end
                if (r_cmd == CMD_PUT) begin
                    if ((r_pv && (r_rd.key >= r_lo)) || w_done) begin
                        n_pv = 1'b0;
                        if (r_pv && (r_rd.key == r_lo)) begin
                            w_we       = 1'b1;
                            w_waddr    = r_didx;
                            w_wdata    = '{key: r_lo, id: r_id};
                            n_out_vld  = 1'b1;
                            n_out_st   = STS_STORED;
                            n_out_last = 1'b1;
                            n_state    = S_IDLE;
                        end else if (r_count == CW'(TABLE_DEPTH)) begin
                            n_out_vld  = 1'b1;
                            n_out_st   = STS_FULL;
                            n_out_last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_pos   = r_pv ? CW'(r_didx) : r_count;
                            n_sh    = r_count;
                            n_state = S_SHIFT;
                        end
                    end
                end else begin
                    // hold one match back so the final one can carry last
                    if (r_pv && (r_rd.key >= r_lo) && (r_rd.key <= r_hi)) begin
                        if (r_hold_vld) begin
                            n_out_vld = 1'b1;
                            n_out_id  = r_hold_id;
                        end
                        n_hold_vld = 1'b1;
                        n_hold_id  = r_rd.id;
                    end else if (w_done) begin
                        n_out_vld  = 1'b1;
                        n_out_id   = r_hold_vld ? r_hold_id : '0;
                        n_out_st   = r_hold_vld ? STS_MATCH : STS_NONE;
                        n_out_last = 1'b1;
                        n_hold_vld = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end

            S_SHIFT: begin
                // move entries pos..count-1 up by one, top first
                if (r_sh > r_pos) begin
                    w_re    = 1'b1;
                    w_raddr = w_sh_m1[AW-1:0];
                    n_sh    = w_sh_m1;
                    n_pv    = 1'b1;
                    n_didx  = w_sh_m1[AW-1:0];
                end
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = r_didx + AW'(1);
                    w_wdata = r_rd;
                end else if (r_sh == r_pos) begin
                    w_we       = 1'b1;
                    w_waddr    = r_pos[AW-1:0];
                    w_wdata    = '{key: r_lo, id: r_id};
                    n_count    = r_count + CW'(1);
                    n_out_vld  = 1'b1;
                    n_out_st   = STS_STORED;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pv       <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pv       <= n_pv;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_addr     <= n_addr;
        r_didx     <= n_didx;
        r_pos      <= n_pos;
        r_sh       <= n_sh;
        r_hold_id  <= n_hold_id;
        r_out_id   <= n_out_id;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_st != STS_MATCH)) |-> r_out_last)
        else $error("non-match result without last");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_st == STS_FULL)) |-> (r_count == CW'(TABLE_DEPTH)))
        else $error("dropped put while table has room");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> ((r_sh >= r_pos) && (r_count < CW'(TABLE_DEPTH))))
        else $error("shift pointer passed insert position");

endmodule

### rtl/timestamp_range_log_store_core.sv
// Timestamp-keyed log store with range retrieval.
// Command channel: drive start high with command, log id, stamps and
// granularity; the beat is taken at a clock edge where busy is low. A put
// stores or replaces an id under its stamp, or drops a new stamp when full; a
// retrieve returns each stored id in the widened range, in ascending order.
// Result channel: o_strobe marks each result beat for one cycle; o_last is
// high on the final beat of a command. The receiver cannot stall, and none
// is needed: at most one result beat leaves per cycle.
// A two-entry command queue sits between the decode front and the table
// engine, so up to three commands wait while the engine works.
// The table engine streams the table memory one entry a cycle through a
// single read port and pops each command when idle, then:
//   retrieve: the scan reads every stored entry, whatever the range;
//   put: the scan stops at the first stamp not below the key, and a new
//   stamp moves every entry above it up one per cycle before the new
//   entry is written into the gap.
// Reset empties the table and the queue at once; no clearing pass is run.
module timestamp_range_log_store_core #(
    parameter int TABLE_DEPTH = trls_pkg::TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = trls_pkg::ID_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [trls_pkg::PORT_ID_W-1:0] i_log_id,
    input  logic [trls_pkg::STAMP_W-1:0]   i_stamp,
    input  logic [trls_pkg::STAMP_W-1:0]   i_stamp_end,
    input  logic [2:0]                     i_granularity,
    output logic                           o_strobe,
    output logic [trls_pkg::PORT_ID_W-1:0] o_result_id,
    output logic [1:0]                     o_status,
    output logic                           o_last
);
    import trls_pkg::*;

    logic       w_push, w_full, w_pop, w_empty;
    t_cmd_entry w_front_entry, w_head;
    t_result    w_result;

    trls_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_command     (i_command),
        .i_log_id      (i_log_id),
        .i_stamp       (i_stamp),
        .i_stamp_end   (i_stamp_end),
        .i_granularity (i_granularity),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_entry       (w_front_entry)
    );

    trls_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    trls_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_entry  (w_head),
        .o_pop    (w_pop),
        .o_result (w_result)
    );

    assign o_strobe    = w_result.vld;
    assign o_result_id = w_result.id;
    assign o_status    = w_result.status;
    assign o_last      = w_result.last;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import trls_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int IDLE_LIMIT  = 1200;
    localparam int DRAIN_WAIT  = 2 * TABLE_DEPTH + 16;

    // The package stops at minute; finer settings all mean "do not widen".
    localparam logic [2:0] GR_SECOND = 3'd5;
    localparam logic [2:0] GR_ODD6   = 3'd6;
    localparam logic [2:0] GR_ODD7   = 3'd7;

    typedef struct packed {
        logic [PORT_ID_W-1:0] id;
        logic [1:0]           status;
        logic                 last;
    } t_log_result;

    typedef struct packed {
        logic                 cmd;
        logic [PORT_ID_W-1:0] id;
        logic [STAMP_W-1:0]   stamp;
        logic [STAMP_W-1:0]   stamp_end;
        logic [2:0]           gran;
        logic                 typed;
        logic [1:0]           sts;
    } t_cmd_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 i_command     = CMD_PUT;
    logic [PORT_ID_W-1:0] i_log_id      = '0;
    logic [STAMP_W-1:0]   i_stamp       = '0;
    logic [STAMP_W-1:0]   i_stamp_end   = '0;
    logic [2:0]           i_granularity = GR_YEAR;
    logic                 busy;
    logic                 o_strobe;
    logic [PORT_ID_W-1:0] o_result_id;
    logic [1:0]           o_status;
    logic                 o_last;

    // Shadow copy of the table, kept in ascending stamp order.
    logic [STAMP_W-1:0]   shadow_key [TABLE_DEPTH];
    logic [PORT_ID_W-1:0] shadow_id  [TABLE_DEPTH];
    int                   shadow_cnt = 0;

    t_log_result due_results [$];
    t_cmd_row    dir_rows [$];

    int err_cnt     = 0;
    int idle_cycles = 0;
    int n_put       = 0;
    int n_get       = 0;
    int n_replace   = 0;
    int n_drop      = 0;
    int n_match     = 0;
    int n_nomatch   = 0;
    int max_hits    = 0;

    always #4 i_clk = ~i_clk;

    timestamp_range_log_store_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_log_id      (i_log_id),
        .i_stamp       (i_stamp),
        .i_stamp_end   (i_stamp_end),
        .i_granularity (i_granularity),
        .o_strobe      (o_strobe),
        .o_result_id   (o_result_id),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    function automatic logic [STAMP_W-1:0] pack_stamp(input int yr, input int mo, input int dy,
                                                      input int hr, input int mi, input int sc);
        return {7'(yr), 4'(mo), 5'(dy), 5'(hr), 6'(mi), 6'(sc)};
    endfunction

    // Force every field finer than g to its floor (range start) or ceiling (range end).
    function automatic logic [STAMP_W-1:0] stretch_stamp(input logic [STAMP_W-1:0] s,
                                                         input logic [2:0] g,
                                                         input logic at_end);
        logic [STAMP_W-1:0] r;
        r = s;
        if (g == GR_YEAR)
            r[25:22] = at_end ? MONTH_LAST : MONTH_FIRST;
        if (g <= GR_MONTH)
            r[21:17] = at_end ? DAY_LAST : DAY_FIRST;
        if (g <= GR_DAY)
            r[16:12] = at_end ? HOUR_LAST : 5'd0;
        if (g <= GR_HOUR)
            r[11:6] = at_end ? MINUTE_LAST : 6'd0;
        if (g <= GR_MINUTE)
            r[5:0] = at_end ? SECOND_LAST : 6'd0;
        return r;
    endfunction

    // Append one expected beat at the tail of the pending list.
    task automatic expect_beat(input t_log_result r);
        due_results.insert(due_results.size(), r);
    endtask

    task automatic add_row(input t_cmd_row row);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Work out the beats one command produces and bring the shadow table up to date.
    task automatic apply_log_cmd(input logic cmd, input logic [PORT_ID_W-1:0] id,
                                 input logic [STAMP_W-1:0] s, input logic [STAMP_W-1:0] e,
                                 input logic [2:0] g, input bit keep);
        int                 pos;
        int                 k;
        int                 last_hit;
        int                 hits;
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] hi;
        t_log_result        r;
        if (cmd == CMD_PUT) begin
            n_put++;
            pos = 0;
            while (pos < shadow_cnt && shadow_key[pos] < s)
                pos++;
            r = '{id: '0, status: STS_STORED, last: 1'b1};
            if (pos < shadow_cnt && shadow_key[pos] == s) begin
                shadow_id[pos] = id;
                n_replace++;
            end else if (shadow_cnt >= TABLE_DEPTH) begin
                r.status = STS_FULL;
                n_drop++;
            end else begin
                for (k = shadow_cnt; k > pos; k--) begin
                    shadow_key[k] = shadow_key[k-1];
                    shadow_id[k]  = shadow_id[k-1];
                end
                shadow_key[pos] = s;
                shadow_id[pos]  = id;
                shadow_cnt++;
            end
            if (keep)
                expect_beat(r);
        end else begin
            n_get++;
            lo = stretch_stamp(s, g, 1'b0);
            hi = stretch_stamp(e, g, 1'b1);
            last_hit = -1;
            hits = 0;
            for (k = 0; k < shadow_cnt; k++) begin
                if (shadow_key[k] >= lo && shadow_key[k] <= hi) begin
                    last_hit = k;
                    hits++;
                end
            end
            if (hits > max_hits)
                max_hits = hits;
            if (keep) begin
                if (last_hit < 0) begin
                    expect_beat('{id: '0, status: STS_NONE, last: 1'b1});
                end else begin
                    for (k = 0; k <= last_hit; k++) begin
                        if (shadow_key[k] >= lo && shadow_key[k] <= hi)
                            expect_beat('{id: shadow_id[k], status: STS_MATCH,
                                          last: (k == last_hit)});
                    end
                end
            end
        end
    endtask

    // Drive one command beat after a random gap; return at the falling edge after it is taken.
    task automatic issue_cmd(input logic cmd, input logic [PORT_ID_W-1:0] id,
                             input logic [STAMP_W-1:0] s, input logic [STAMP_W-1:0] e,
                             input logic [2:0] g, input bit typed, input logic [1:0] sts);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= cmd;
        i_log_id      <= id;
        i_stamp       <= s;
        i_stamp_end   <= e;
        i_granularity <= g;
        do @(posedge i_clk); while (busy);
        apply_log_cmd(cmd, id, s, e, g, !typed);
        if (typed)
            expect_beat('{id: '0, status: sts, last: 1'b1});
        @(negedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (err_cnt < 100)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // Mostly plausible stamps, some reused keys, some with fields out of range, some raw noise.
    function automatic logic [STAMP_W-1:0] draw_stamp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return {1'($urandom_range(0, 1)), 32'($urandom())};
        if (pick == 1)
            return pack_stamp($urandom_range(0, 127), $urandom_range(0, 15),
                              $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 63), $urandom_range(0, 63));
        if (pick <= 4 && shadow_cnt > 0)
            return shadow_key[$urandom_range(0, shadow_cnt - 1)];
        return pack_stamp($urandom_range(0, 3), $urandom_range(1, 12), $urandom_range(1, 31),
                          $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    task automatic random_get(input bit wide);
        logic [STAMP_W-1:0] s;
        logic [STAMP_W-1:0] e;
        logic [STAMP_W-1:0] t;
        logic [2:0]         g;
        s = draw_stamp();
        e = draw_stamp();
        // Keep most ranges well ordered; leave some reversed on purpose.
        if (s > e && $urandom_range(0, 5) != 0) begin
            t = s;
            s = e;
            e = t;
        end
        if (wide && $urandom_range(0, 2) == 0) begin
            s = pack_stamp(0, 1, 1, 0, 0, 0);
            e = pack_stamp($urandom_range(1, 3), 12, 31, 23, 59, 59);
        end
        g = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
        issue_cmd(CMD_GET, 16'($urandom()), s, e, g, 1'b0, STS_MATCH);
    endtask

    task automatic random_put();
        issue_cmd(CMD_PUT, 16'($urandom()), draw_stamp(), {1'($urandom_range(0, 1)),
                  32'($urandom())}, 3'($urandom_range(0, 7)), 1'b0, STS_STORED);
    endtask

    always @(posedge i_clk) begin
        t_log_result want;
        if (i_rst_n && o_strobe) begin
            if (o_status == STS_MATCH)
                n_match++;
            if (o_status == STS_NONE)
                n_nomatch++;
            if (due_results.size() == 0) begin
                flag_mismatch("result beat with nothing pending",
                              32'({o_result_id, o_status, o_last}), '0);
            end else begin
                want = due_results.pop_front();
                if (o_result_id !== want.id)
                    flag_mismatch("result_id", 32'(o_result_id), 32'(want.id));
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_last !== want.last)
                    flag_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timestamp_range_log_store_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [STAMP_W-1:0] mid;
        logic [STAMP_W-1:0] all_ones;
        t_cmd_row           row;
        int                 k;
        mid      = pack_stamp(24, 6, 15, 12, 30, 30);
        all_ones = {STAMP_W{1'b1}};

        add_row('{CMD_GET, 16'h5A5A, '0, all_ones, GR_SECOND, 1'b1, STS_NONE});
        add_row('{CMD_PUT, 16'h0000, '0, '0, GR_YEAR, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'hFFFF, all_ones, all_ones, GR_ODD7, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h1234, mid, '0, GR_SECOND, 1'b1, STS_STORED});
        // same stamp again: replace the id in place
        add_row('{CMD_PUT, 16'hABCD, mid, '0, GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h0001, pack_stamp(24, 6, 15, 12, 30, 0), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h0002, pack_stamp(24, 6, 15, 12, 0, 0), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h0003, pack_stamp(24, 6, 15, 0, 0, 0), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h0004, pack_stamp(24, 6, 1, 0, 0, 0), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h0005, pack_stamp(24, 1, 1, 0, 0, 0), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h0006, pack_stamp(24, 12, 31, 23, 59, 59), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_PUT, 16'h0007, pack_stamp(23, 12, 31, 23, 59, 59), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        // fields beyond their calendar ranges are stored as given
        add_row('{CMD_PUT, 16'h0008, pack_stamp(127, 0, 0, 31, 63, 63), '0,
                  GR_SECOND, 1'b1, STS_STORED});
        add_row('{CMD_GET, 16'hFFFF, mid, mid, GR_YEAR, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, mid, mid, GR_MONTH, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, mid, mid, GR_DAY, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, mid, mid, GR_HOUR, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, mid, mid, GR_MINUTE, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, mid, mid, GR_SECOND, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, mid, mid, GR_ODD6, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, mid, mid, GR_ODD7, 1'b0, STS_MATCH});
        // start after end: nothing can match
        add_row('{CMD_GET, 16'h0000, pack_stamp(25, 1, 1, 0, 0, 0),
                  pack_stamp(24, 12, 31, 23, 59, 59), GR_SECOND, 1'b1, STS_NONE});
        add_row('{CMD_GET, 16'h0000, '0, all_ones, GR_SECOND, 1'b0, STS_MATCH});
        add_row('{CMD_GET, 16'h0000, pack_stamp(127, 15, 0, 31, 63, 63), all_ones,
                  GR_YEAR, 1'b0, STS_MATCH});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            issue_cmd(row.cmd, row.id, row.stamp, row.stamp_end, row.gran, row.typed, row.sts);
        end

        // Mixed traffic while the table grows.
        for (k = 0; k < 110; k++) begin
            if ($urandom_range(0, 99) < 50)
                random_put();
            else
                random_get(1'b0);
        end

        // Fill the table, then push against the full table: new stamps drop, known ones replace.
        while (shadow_cnt < TABLE_DEPTH)
            issue_cmd(CMD_PUT, 16'($urandom()), pack_stamp($urandom_range(0, 3),
                      $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
                      $urandom_range(0, 59), $urandom_range(0, 59)), '0, GR_SECOND, 1'b0,
                      STS_STORED);
        issue_cmd(CMD_PUT, 16'h0BAD, all_ones - 33'd1, '0, GR_SECOND, 1'b0, STS_FULL);
        issue_cmd(CMD_PUT, 16'h7E57, 33'd1, '0, GR_SECOND, 1'b0, STS_FULL);
        issue_cmd(CMD_PUT, 16'h4321, all_ones, '0, GR_SECOND, 1'b0, STS_STORED);
        for (k = 0; k < 6; k++)
            random_put();

        // Full table: long result bursts from wide ranges.
        for (k = 0; k < 90; k++) begin
            if ($urandom_range(0, 99) < 70)
                random_get(1'b1);
            else
                random_put();
        end

        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d puts (%0d id replacements, %0d dropped on a full table)",
                 n_put, n_replace, n_drop);
        $display("and %0d retrieves (%0d match beats, %0d empty, up to %0d beats in one burst).",
                 n_get, n_match, n_nomatch, max_hits);
        if (err_cnt == 0) begin
            $display("timestamp_range_log_store_core verification clean");
        end else begin
            $display("timestamp_range_log_store_core verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/trls_pkg.sv
rtl/trls_front.sv
rtl/trls_fifo.sv
rtl/trls_back.sv
rtl/timestamp_range_log_store_core.sv
sim/tb.sv
